// ===== sv/rbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared widths, codes and saturation helper of the rational B-spline curve
// evaluator.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned ORDER_W = 4;
  localparam int unsigned LAST_W  = 6;
  localparam int unsigned NKNOT_W = 7;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned MAX_ORDER_DEF  = 8;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NKNOT = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_RST = 4'd4;
  localparam logic [LAST_W-1:0]  LAST_RST  = 6'd3;
  localparam logic [NKNOT_W-1:0] NKNOT_RST = 7'd8;

  // item modes
  localparam logic [MODE_W-1:0] MODE_KNOT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVAL  = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_W  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FEW_KN  = 2'd2;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // clamp a wide signed value into 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = S32_MAX;
    else if (v < -64'sh0000_0000_8000_0000) r = S32_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rbc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_in_if / rbc_out_if
// Valid/ready channels for input items and evaluated points.
// ----------------------------------------------------------------------------
interface rbc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [rbc_pkg::MODE_W-1:0]        mode;
  logic        [rbc_pkg::INDEX_W-1:0]       index;
  logic signed [rbc_pkg::DATA_W-1:0]        coord_x;
  logic signed [rbc_pkg::DATA_W-1:0]        coord_y;
  logic signed [rbc_pkg::DATA_W-1:0]        coord_z;
  logic signed [rbc_pkg::DATA_W-1:0]        weight;
  logic signed [rbc_pkg::DATA_W-1:0]        param;
  modport source (output valid, mode, index, coord_x, coord_y, coord_z, weight, param,
                  input ready);
  modport sink   (input valid, mode, index, coord_x, coord_y, coord_z, weight, param,
                  output ready);
endinterface

interface rbc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rbc_pkg::DATA_W-1:0]        point_x;
  logic signed [rbc_pkg::DATA_W-1:0]        point_y;
  logic signed [rbc_pkg::DATA_W-1:0]        point_z;
  logic        [rbc_pkg::STAT_W-1:0]        status;
  modport source (output valid, point_x, point_y, point_z, status, input ready);
  modport sink   (input valid, point_x, point_y, point_z, status, output ready);
endinterface
`default_nettype wire

// ===== sv/rbc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/rbc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbc_div
// Radix-2 restoring divider, 64-bit signed by 32-bit signed, quotient
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module rbc_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic signed [rbc_pkg::PROD_W-1:0]     dividend_i,
  input  wire logic signed [rbc_pkg::DATA_W-1:0]     divisor_i,
  output      logic                                  done_o,
  output      logic signed [rbc_pkg::DATA_W-1:0]     quot_o
);

  localparam int unsigned PW = rbc_pkg::PROD_W;
  localparam int unsigned DW = rbc_pkg::DATA_W;

  logic               busy_q, done_q;
  logic [5:0]         cnt_q;
  logic [DW:0]        rem_q;
  logic [PW-1:0]      quo_q;
  logic [DW-1:0]      dvs_q;
  logic               neg_q;
  logic [DW:0]        shifted;
  logic               fits;
  logic               big;

  assign shifted = {rem_q[DW-1:0], quo_q[PW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[PW-1] ? PW'(-dividend_i) : PW'(dividend_i);
      dvs_q <= divisor_i[DW-1] ? DW'(-divisor_i) : DW'(divisor_i);
      neg_q <= dividend_i[PW-1] ^ divisor_i[DW-1];
      rem_q <= '0;
      cnt_q <= 6'd63;
    end else if (busy_q) begin
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_q <= {quo_q[PW-2:0], fits};
      cnt_q <= cnt_q - 6'd1;
    end
  end

  // clamp the magnitude to what fits the sign
  assign big = neg_q ? (quo_q > 64'h0000_0000_8000_0000) : (quo_q > 64'h0000_0000_7FFF_FFFF);

  always_comb begin
    if (big) quot_o = neg_q ? rbc_pkg::S32_MIN : rbc_pkg::S32_MAX;
    else if (neg_q) quot_o = DW'(-quo_q[DW-1:0]);
    else quot_o = quo_q[DW-1:0];
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== sv/rational_bspline_curve_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_bspline_curve_eval
// Rational B-spline curve evaluator: knot and control point stores in RAM,
// Cox-de Boor basis triangle built level by level in a basis RAM, weighted
// sums and final divisions on one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word carries
//  in_i     in   valid/ready    mode, index, coord_x/y/z, weight, param
//  out_o    out  valid/ready    point_x/y/z, status (one per evaluate word)
//  cfg      in   cfg_we_i       cfg_idx_i selects order/last_point/num_knots
//
//  A load word is taken only in the idle state. An evaluate word builds basis
//  level r (r = 1..k) over m+k-r+1 entries; each entry costs knot and basis
//  fetches plus up to two divisions on the serial divider, then each of the m+1
//  points is summed with its weight; the three final divisions follow. The
//  divider dominates. Reset sets configuration to defaults and clears control;
//  stores hold nothing until loaded. A stalled output holds the finished word;
//  load words are still taken meanwhile, a new evaluation waits at its end.
// ----------------------------------------------------------------------------
module rational_bspline_curve_eval #(
  parameter int unsigned MAX_POINTS = rbc_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_ORDER  = rbc_pkg::MAX_ORDER_DEF,
  parameter int unsigned FRAC_BITS  = rbc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  rbc_in_if.sink                                 in_i,
  rbc_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rbc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rbc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DW  = rbc_pkg::DATA_W;
  localparam int unsigned PW  = rbc_pkg::PROD_W;
  localparam int unsigned KD  = MAX_POINTS + MAX_ORDER;
  localparam int unsigned KAW = $clog2(KD);
  localparam int unsigned PAW = $clog2(MAX_POINTS);
  localparam int unsigned JW  = $clog2(KD + MAX_ORDER + 1);
  localparam int unsigned KW  = $clog2(MAX_ORDER + 2);
  localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FRAC_BITS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH  = 4'd1;
  localparam logic [3:0] S_TERM   = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DWAIT  = 4'd4;
  localparam logic [3:0] S_BWR    = 4'd5;
  localparam logic [3:0] S_SRD    = 4'd6;
  localparam logic [3:0] S_SW     = 4'd7;
  localparam logic [3:0] S_SWA    = 4'd8;
  localparam logic [3:0] S_SX     = 4'd9;
  localparam logic [3:0] S_SXA    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;
  localparam logic [3:0] S_FDIV   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // configuration
  logic [rbc_pkg::ORDER_W-1:0] order_q;
  logic [rbc_pkg::LAST_W-1:0]  last_q;
  logic [rbc_pkg::NKNOT_W-1:0] nknot_q;

  // sequencer
  logic [3:0]    state_q;
  logic [JW-1:0] j_q, m_q;
  logic [KW-1:0] r_q, k_q;
  logic [2:0]    fc_q;
  logic          tsel_q, ph_q, koob_q;

  // datapath
  logic signed [DW-1:0] t_q, nj_q, nj1_q, acc_q, dv_q, tmp_q, den_q;
  logic signed [DW-1:0] kr_q  [4];
  logic signed [DW-1:0] num_q [3];
  logic signed [DW-1:0] pt_q  [3];
  logic signed [PW-1:0] p_q;
  logic [rbc_pkg::STAT_W-1:0] stat_q;

  // output register
  logic                       ovalid_q;
  logic signed [DW-1:0]       ox_q, oy_q, oz_q;
  logic [rbc_pkg::STAT_W-1:0] ost_q;

  logic accept, out_free;
  logic [KW-1:0]  k_eff;
  logic [JW-1:0]  m_eff;
  logic           few_knots;
  logic [JW-1:0]  kaddr, jlast;
  logic           past_knots;
  logic signed [DW-1:0] d_sel, diff_sel, nb_sel, mul_a, mul_b, coord_sel;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] fprod;

  logic               k_we, p_we, b_we;
  logic [DW-1:0]      k_rdata, b_rdata;
  logic [4*DW-1:0]    p_rdata;
  logic               div_start, div_done;
  logic signed [DW-1:0] div_q;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free  = !ovalid_q || out_o.ready;

  // clamp order and last point to what the stores hold
  always_comb begin
    if (order_q == '0) k_eff = KW'(1);
    else if (32'(order_q) > MAX_ORDER) k_eff = KW'(MAX_ORDER);
    else k_eff = KW'(order_q);
    if (32'(last_q) > MAX_POINTS - 1) m_eff = JW'(MAX_POINTS - 1);
    else m_eff = JW'(last_q);
  end
  assign few_knots = 16'(nknot_q) < (16'(m_eff) + 16'd1 + 16'(k_eff));

  // knot fetch order: j, j+r-1, j+1, j+r
  always_comb begin
    case (fc_q)
      3'd0:    kaddr = j_q;
      3'd1:    kaddr = j_q + JW'(r_q) - JW'(1);
      3'd2:    kaddr = j_q + JW'(1);
      default: kaddr = j_q + JW'(r_q);
    endcase
  end
  assign jlast      = m_q + JW'(k_q) - JW'(r_q);
  assign past_knots = (16'(j_q) + 16'd2) > 16'(nknot_q);

  // term operands
  always_comb begin
    if (tsel_q) begin
      d_sel    = rbc_pkg::sat32(PW'(kr_q[3]) - PW'(kr_q[2]));
      diff_sel = rbc_pkg::sat32(PW'(kr_q[3]) - PW'(t_q));
      nb_sel   = nj1_q;
    end else begin
      d_sel    = rbc_pkg::sat32(PW'(kr_q[1]) - PW'(kr_q[0]));
      diff_sel = rbc_pkg::sat32(PW'(t_q) - PW'(kr_q[0]));
      nb_sel   = nj_q;
    end
  end

  always_comb begin
    case (fc_q[1:0])
      2'd0:    coord_sel = p_rdata[DW-1:0];
      2'd1:    coord_sel = p_rdata[2*DW-1:DW];
      default: coord_sel = p_rdata[3*DW-1:2*DW];
    endcase
  end

  // one shared multiplier
  always_comb begin
    case (state_q)
      S_TERM:  begin mul_a = diff_sel;                mul_b = nb_sel;  end
      S_SW:    begin mul_a = p_rdata[4*DW-1:3*DW];    mul_b = b_rdata; end
      default: begin mul_a = coord_sel;               mul_b = tmp_q;   end
    endcase
  end
  assign prod  = PW'(mul_a) * PW'(mul_b);
  // floor shift of the registered product, then clamp
  assign fprod = rbc_pkg::sat32(p_q >>> FRAC_BITS);

  assign div_start = (state_q == S_DSTART);
  assign b_we      = (state_q == S_BWR);
  assign k_we = accept && (in_i.mode == rbc_pkg::MODE_KNOT) && (16'(in_i.index) < 16'(KD));
  assign p_we = accept && (in_i.mode == rbc_pkg::MODE_POINT)
             && (16'(in_i.index) < 16'(MAX_POINTS));

  rbc_ram #(.WIDTH(DW), .DEPTH(KD)) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (KAW'(in_i.index)),
    .wdata_i (in_i.param),
    .raddr_i (kaddr[KAW-1:0]),
    .rdata_o (k_rdata)
  );

  rbc_ram #(.WIDTH(4*DW), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (PAW'(in_i.index)),
    .wdata_i ({in_i.weight, in_i.coord_z, in_i.coord_y, in_i.coord_x}),
    .raddr_i (j_q[PAW-1:0]),
    .rdata_o (p_rdata)
  );

  // basis triangle, updated in place level by level
  rbc_ram #(.WIDTH(DW), .DEPTH(KD)) u_basis_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (j_q[KAW-1:0]),
    .wdata_i (acc_q),
    .raddr_i ((state_q == S_FETCH && fc_q != 3'd0) ? KAW'(j_q + JW'(1)) : j_q[KAW-1:0]),
    .rdata_o (b_rdata)
  );

  rbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (p_q),
    .divisor_i  (dv_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q  <= rbc_pkg::ORDER_RST;
      last_q   <= rbc_pkg::LAST_RST;
      nknot_q  <= rbc_pkg::NKNOT_RST;
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbc_pkg::CFG_ORDER: order_q <= cfg_data_i[rbc_pkg::ORDER_W-1:0];
          rbc_pkg::CFG_LAST:  last_q  <= cfg_data_i[rbc_pkg::LAST_W-1:0];
          rbc_pkg::CFG_NKNOT: nknot_q <= cfg_data_i[rbc_pkg::NKNOT_W-1:0];
          default: ;
        endcase
      end
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && in_i.mode == rbc_pkg::MODE_EVAL) begin
            state_q <= few_knots ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: if (fc_q == 3'd4) state_q <= S_TERM;
        S_TERM: begin
          if (r_q == KW'(1) || past_knots) state_q <= S_BWR;
          else if (d_sel != '0) state_q <= S_DSTART;
          else if (tsel_q) state_q <= S_BWR;
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            if (ph_q) state_q <= (fc_q == 3'd2) ? S_DONE : S_FDIV;
            else state_q <= tsel_q ? S_BWR : S_TERM;
          end
        end
        S_BWR: begin
          if (j_q == jlast && r_q == k_q) state_q <= S_SRD;
          else state_q <= S_FETCH;
        end
        S_SRD: state_q <= S_SW;
        S_SW:  state_q <= S_SWA;
        S_SWA: state_q <= S_SX;
        S_SX:  state_q <= S_SXA;
        S_SXA: begin
          if (fc_q != 3'd2) state_q <= S_SX;
          else state_q <= (j_q == m_q) ? S_FIN : S_SRD;
        end
        S_FIN:  state_q <= (den_q == '0) ? S_DONE : S_FDIV;
        S_FDIV: state_q <= S_DSTART;
        S_DONE: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    koob_q <= 32'(kaddr) >= KD;
    case (state_q)
      S_IDLE: begin
        t_q   <= in_i.param;
        k_q   <= k_eff;
        m_q   <= m_eff;
        j_q   <= '0;
        r_q   <= KW'(1);
        fc_q  <= '0;
        ph_q  <= 1'b0;
        stat_q <= rbc_pkg::ST_FEW_KN;
        for (int c = 0; c < 3; c++) pt_q[c] <= '0;
      end
      S_FETCH: begin
        if (fc_q != 3'd0) kr_q[2'(fc_q - 3'd1)] <= koob_q ? '0 : k_rdata;
        if (fc_q == 3'd1) nj_q  <= b_rdata;
        if (fc_q == 3'd2) nj1_q <= b_rdata;
        fc_q   <= (fc_q == 3'd4) ? 3'd0 : fc_q + 3'd1;
        tsel_q <= 1'b0;
        acc_q  <= '0;
      end
      S_TERM: begin
        if (r_q == KW'(1)) begin
          acc_q <= (!past_knots && t_q >= kr_q[0] && t_q < kr_q[2]) ? ONE : '0;
        end else if (!past_knots) begin
          p_q    <= prod;
          dv_q   <= d_sel;
          if (d_sel == '0) tsel_q <= 1'b1;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          if (ph_q) begin
            pt_q[fc_q[1:0]] <= div_q;
            fc_q <= fc_q + 3'd1;
          end else begin
            acc_q  <= rbc_pkg::sat32(PW'(acc_q) + PW'(div_q));
            tsel_q <= 1'b1;
          end
        end
      end
      S_BWR: begin
        if (j_q == jlast) begin
          j_q <= '0;
          r_q <= r_q + KW'(1);
        end else begin
          j_q <= j_q + JW'(1);
        end
        den_q <= '0;
        for (int c = 0; c < 3; c++) num_q[c] <= '0;
      end
      S_SW:  p_q <= prod;
      S_SWA: begin
        tmp_q <= fprod;
        den_q <= rbc_pkg::sat32(PW'(den_q) + PW'(fprod));
        fc_q  <= '0;
      end
      S_SX:  p_q <= prod;
      S_SXA: begin
        num_q[fc_q[1:0]] <= rbc_pkg::sat32(PW'(num_q[fc_q[1:0]]) + PW'(fprod));
        fc_q <= fc_q + 3'd1;
        if (fc_q == 3'd2) j_q <= j_q + JW'(1);
      end
      S_FIN: begin
        fc_q   <= '0;
        ph_q   <= 1'b1;
        stat_q <= (den_q == '0) ? rbc_pkg::ST_ZERO_W : rbc_pkg::ST_OK;
      end
      S_FDIV: begin
        p_q  <= PW'(num_q[fc_q[1:0]]) <<< FRAC_BITS;
        dv_q <= den_q;
      end
      S_DONE: begin
        if (out_free) begin
          ox_q  <= pt_q[0];
          oy_q  <= pt_q[1];
          oz_q  <= pt_q[2];
          ost_q <= stat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.point_x = ox_q;
  assign out_o.point_y = oy_q;
  assign out_o.point_z = oz_q;
  assign out_o.status  = ost_q;

  // hold the wait state until the divider reports
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWAIT && !div_done) |=> (state_q == S_DWAIT))
    else $error("left divider wait before quotient was ready");

  // an error word carries a zero point
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != rbc_pkg::ST_OK) |->
      (out_o.point_x == '0 && out_o.point_y == '0 && out_o.point_z == '0))
    else $error("error status with nonzero point");

  // basis writes never go past the clamped order
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BWR) |-> (r_q <= k_q && r_q != '0))
    else $error("basis level out of range");

  // a finished word is never overwritten while it waits
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("pending result dropped");

endmodule
`default_nettype wire
